/* sv/uv_sphere_mesh_generator_assert.svh */
// ---------------------------------------------------------------------------
// UV sphere mesh generator assertion macros
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

// same-cycle implication
`define UVSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UVSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/uvs_pkg.sv */
// ---------------------------------------------------------------------------
// UV sphere package
// Shared codes, register indexes, sine coefficients and Q30 helpers.
// ---------------------------------------------------------------------------
package uvs_pkg;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_QUAD   = 1'b1
  } op_e;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 2'd1;

  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [8:0]  SEG_RST    = 9'd8;

  localparam int LANES = 4;
  localparam logic [2:0] IDX_LAST = 3'd5;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] CF1 = 31'd1686629713;
  localparam logic [30:0] CF3 = 31'd693598669;
  localparam logic [30:0] CF5 = 31'd85569306;
  localparam logic [30:0] CF7 = 31'd5026995;
  localparam logic [30:0] CF9 = 31'd172272;

  typedef struct packed {
    logic             op;
    logic             bad;
    logic [15:0]      u;
    logic [15:0]      v;
    logic [5:0][17:0] idx;
  } carry_t;

  function automatic logic [30:0] q30_mul(input logic [30:0] a, input logic [30:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b) + 63'(64'd1 << 29);
    return 31'(p >> 30);
  endfunction

endpackage

/* sv/uv_sphere_mesh_generator.sv */
// ---------------------------------------------------------------------------
// UV sphere mesh generator
// Pipelined vertex and quad-index generator for a configurable UV sphere.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i/in_stall_o  | op, grid_row, grid_column
//  out     | source    | out_valid_o/out_stall_i| position, normal, uv, index, flags
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  Each request passes through the numbered stages and then the output register.
//  Vertex requests sustain one per cycle while the output is not stalled and
//  no divide runs; a quad request holds the pipeline while the output sequencer
//  walks its six corner indices. A segment_count write starts a serial
//  reciprocal divider that blocks input until the quotient is complete.
//  All stages move together on one advance enable; a stalled output freezes them.
//  Reset clears valid bits and loads the reset radius, segment count and reciprocal.
`include "uv_sphere_mesh_generator_assert.svh"

module uv_sphere_mesh_generator
  import uvs_pkg::*;
#(
  parameter int MAX_SEGMENTS = 256,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [8:0]            grid_row_i,
  input  logic [9:0]            grid_column_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [16:0]    pos_x_o,
  output logic signed [16:0]    pos_y_o,
  output logic signed [16:0]    pos_z_o,
  output logic signed [15:0]    norm_x_o,
  output logic signed [15:0]    norm_y_o,
  output logic signed [15:0]    norm_z_o,
  output logic [15:0]           tex_u_o,
  output logic [15:0]           tex_v_o,
  output logic [17:0]           vertex_index_o,
  output logic                  last_of_run_o,
  output logic                  bad_request_o
);

  localparam int AB  = ANGLE_BITS;
  localparam int RW  = (AB + 12 > 26) ? AB + 12 : 26;
  localparam int NW  = AB + 11;
  localparam int TW  = 25;
  localparam int QW  = AB + 1;
  localparam int PLW = NW + RW - 1;
  localparam int PUW = TW + RW - 1;
  localparam int PVW = TW + RW;
  localparam int DCW = $clog2(RW + 2);
  localparam logic [RW-1:0] RT_RST = RW'((64'd1 << RW) / 64'(SEG_RST));
  localparam logic [AB-1:0] QTR = AB'(64'd1 << (AB - 2));

  // configuration and reciprocal divider
  logic [15:0]    rad_q;
  logic [8:0]     seg_q;
  logic [RW-1:0]  rt_q;
  logic           div_busy_q;
  logic [DCW-1:0] div_cnt_q;
  logic [8:0]     div_rem_q;
  logic [9:0]     div_sh;
  logic           div_ge;
  logic [9:0]     div_rem_d;
  logic           cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    div_sh    = {div_rem_q, (div_cnt_q == '0)};
    div_ge    = div_sh >= {1'b0, seg_q};
    div_rem_d = div_ge ? (div_sh - {1'b0, seg_q}) : div_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q      <= RADIUS_RST;
      seg_q      <= SEG_RST;
      rt_q       <= RT_RST;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
    end else if (cfg_we && cfg_index_i == REG_SEGMENTS) begin
      seg_q      <= cfg_data_i[8:0];
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
    end else begin
      if (cfg_we && cfg_index_i == REG_RADIUS) begin
        rad_q <= cfg_data_i;
      end
      if (div_busy_q) begin
        div_rem_q <= div_rem_d[8:0];
        rt_q      <= {rt_q[RW-2:0], div_ge};
        div_cnt_q <= div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(RW)) begin
          div_busy_q <= 1'b0;
        end
      end
    end
  end

  // pipeline control
  logic        adv;
  logic        in_acc;
  logic [12:1] vld_q;
  logic        out_vld_q;
  logic [2:0]  out_cnt_q;
  logic        out_multi_q;
  logic        out_last;

  assign out_last   = !out_multi_q || out_cnt_q == IDX_LAST;
  assign adv        = !out_vld_q || (!out_stall_i && out_last);
  assign in_stall_o = div_busy_q || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  logic [9:0] h;
  assign h = {seg_q, 1'b0};

  // stage 1
  logic       s1_op_q, s1_bad_q;
  logic [8:0] s1_row_q;
  logic [9:0] s1_col_q;
  logic       in_bad;

  always_comb begin
    in_bad = seg_q < 9'd3 || 32'(seg_q) > MAX_SEGMENTS || grid_column_i > h ||
             (op_i == OP_VERTEX ? grid_row_i > seg_q : grid_row_i >= seg_q);
  end

  // stage 2
  logic [NW-1:0]  nlon1, nlat1;
  logic [TW-1:0]  nu1, nv1;
  logic [PLW-1:0] s2_plon_q, s2_plat_q;
  logic [PUW-1:0] s2_pu_q;
  logic [PVW-1:0] s2_pv_q;
  logic [18:0]    s2_top_q;
  logic           s2_op_q, s2_bad_q;
  logic [8:0]     s2_row_q;
  logic [9:0]     s2_col_q;

  always_comb begin
    nlon1 = (NW'(s1_col_q) << AB) + NW'(seg_q);
    nlat1 = (NW'(s1_row_q) << AB) + NW'(seg_q);
    nu1   = (TW'(s1_col_q) << 15) + TW'(seg_q);
    nv1   = (TW'(s1_row_q) << 15) + TW'(seg_q >> 1);
  end

  // stage 3
  logic [QW-1:0]    q0lon, q0lat;
  logic [15:0]      q0u, q0v;
  logic [9:0]       stride2, c1_2;
  logic [19:0]      bot2;
  logic [QW-1:0]    s3_q0lon_q, s3_q0lat_q;
  logic [15:0]      s3_q0u_q, s3_q0v_q;
  logic [NW-1:0]    s3_dlon_q, s3_dlat_q;
  logic [25:0]      s3_du_q;
  logic [24:0]      s3_dv_q;
  logic [5:0][17:0] s3_idx_q;
  logic             s3_op_q, s3_bad_q;
  logic [8:0]       s3_row_q;
  logic [9:0]       s3_col_q;

  always_comb begin
    q0lon   = QW'(s2_plon_q >> RW);
    q0lat   = QW'(s2_plat_q >> RW);
    q0u     = 16'(s2_pu_q >> RW);
    q0v     = 16'(s2_pv_q >> RW);
    stride2 = h + 10'd1;
    c1_2    = (s2_col_q == h) ? 10'd0 : s2_col_q + 10'd1;
    bot2    = 20'(s2_top_q) + 20'(stride2);
  end

  // stage 4
  logic [NW-1:0]   nlon3, nlat3, rlon, rlat;
  logic [TW-1:0]   nu3, nv3;
  logic [25:0]     ru;
  logic [24:0]     rv;
  logic [QW-1:0]   qlon, qlat;
  logic [15:0]     qu, qv;
  logic [AB-1:0]   ph [LANES];
  logic [1:0]      quad [LANES];
  logic [AB-2:0]   rr [LANES];
  logic [30:0]     z3 [LANES];
  logic [LANES-1:0] ng3;
  carry_t          car3;

  always_comb begin
    nlon3 = (NW'(s3_col_q) << AB) + NW'(seg_q);
    nlat3 = (NW'(s3_row_q) << AB) + NW'(seg_q);
    nu3   = (TW'(s3_col_q) << 15) + TW'(seg_q);
    nv3   = (TW'(s3_row_q) << 15) + TW'(seg_q >> 1);
    rlon  = nlon3 - s3_dlon_q;
    rlat  = nlat3 - s3_dlat_q;
    ru    = 26'(nu3) - s3_du_q;
    rv    = nv3 - s3_dv_q;
    qlon  = s3_q0lon_q + QW'(rlon >= NW'(h));
    qlat  = s3_q0lat_q + QW'(rlat >= NW'(h));
    qu    = s3_q0u_q + 16'(ru >= 26'(h));
    qv    = s3_q0v_q + 16'(rv >= 25'(seg_q));
    ph[0] = qlat[AB-1:0] - QTR;
    ph[1] = ph[0] + QTR;
    ph[2] = qlon[AB-1:0];
    ph[3] = ph[2] + QTR;
    for (int l = 0; l < LANES; l++) begin
      quad[l] = ph[l][AB-1:AB-2];
      rr[l]   = quad[l][0] ? ((AB-1)'(QTR) - (AB-1)'(ph[l][AB-3:0]))
                           : (AB-1)'(ph[l][AB-3:0]);
      z3[l]   = 31'(rr[l]) << (32 - AB);
      ng3[l]  = quad[l][1];
    end
    car3.op  = s3_op_q;
    car3.bad = s3_bad_q;
    car3.u   = qu;
    car3.v   = 16'd32768 - qv;
    car3.idx = s3_idx_q;
  end

  // sine polynomial stages 5..10
  logic [30:0]      z_q  [4:9][LANES];
  logic [30:0]      zz_q [5:9][LANES];
  logic [30:0]      tp_q [6:9][LANES];
  logic [30:0]      sn_q [LANES];
  logic [LANES-1:0] ng_q [4:10];
  carry_t           car_q [4:12];
  logic [30:0]      coef [6:9];
  logic [30:0]      sfin [LANES];

  always_comb begin
    coef[6] = CF7;
    coef[7] = CF5;
    coef[8] = CF3;
    coef[9] = CF1;
    for (int l = 0; l < LANES; l++) begin
      sfin[l] = q30_mul(z_q[9][l], tp_q[9][l]);
      if (sfin[l] > Q30_ONE) begin
        sfin[l] = Q30_ONE;
      end
    end
  end

  // stages 11, 12
  logic [30:0] mag_q [3];
  logic [2:0]  mng_q [11:12];
  logic [31:0] nrnd [3];
  logic [14:0] nr_q [3];
  logic [46:0] pp_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nrnd[j] = (32'(mag_q[j]) + 32'd32768) >> 16;
      if (nrnd[j] > 32'd16384) begin
        nrnd[j] = 32'd16384;
      end
    end
  end

  // output register
  logic signed [16:0] out_pos_q [3];
  logic signed [15:0] out_nrm_q [3];
  logic [15:0]        out_u_q, out_v_q;
  logic [5:0][17:0]   out_idx_q;
  logic               out_bad_q;
  logic [47:0]        prnd [3];
  logic [16:0]        pmag [3];
  logic               vtx12;

  always_comb begin
    vtx12 = car_q[12].op == OP_VERTEX && !car_q[12].bad;
    for (int j = 0; j < 3; j++) begin
      prnd[j] = 48'(pp_q[j]) + 48'(64'd1 << 29);
      pmag[j] = 17'(prnd[j] >> 30);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      if (adv) begin
        vld_q     <= {vld_q[11:1], in_acc};
        out_vld_q <= vld_q[12];
        out_cnt_q <= '0;
      end else if (out_vld_q && !out_stall_i) begin
        out_cnt_q <= out_cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q  <= op_i;
      s1_bad_q <= in_bad;
      s1_row_q <= grid_row_i;
      s1_col_q <= grid_column_i;

      s2_plon_q <= PLW'(nlon1) * PLW'(rt_q[RW-1:1]);
      s2_plat_q <= PLW'(nlat1) * PLW'(rt_q[RW-1:1]);
      s2_pu_q   <= PUW'(nu1) * PUW'(rt_q[RW-1:1]);
      s2_pv_q   <= PVW'(nv1) * PVW'(rt_q);
      s2_top_q  <= 19'(s1_row_q) * 19'(h + 10'd1);
      s2_op_q   <= s1_op_q;
      s2_bad_q  <= s1_bad_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;

      s3_q0lon_q <= q0lon;
      s3_q0lat_q <= q0lat;
      s3_q0u_q   <= q0u;
      s3_q0v_q   <= q0v;
      s3_dlon_q  <= NW'(q0lon) * NW'(h);
      s3_dlat_q  <= NW'(q0lat) * NW'(h);
      s3_du_q    <= 26'(q0u) * 26'(h);
      s3_dv_q    <= 25'(q0v) * 25'(seg_q);
      s3_idx_q[0] <= 18'(20'(s2_top_q) + 20'(s2_col_q));
      s3_idx_q[1] <= 18'(20'(s2_top_q) + 20'(c1_2));
      s3_idx_q[2] <= 18'(bot2 + 20'(s2_col_q));
      s3_idx_q[3] <= 18'(20'(s2_top_q) + 20'(c1_2));
      s3_idx_q[4] <= 18'(bot2 + 20'(c1_2));
      s3_idx_q[5] <= 18'(bot2 + 20'(s2_col_q));
      s3_op_q  <= s2_op_q;
      s3_bad_q <= s2_bad_q;
      s3_row_q <= s2_row_q;
      s3_col_q <= s2_col_q;

      z_q[4]   <= z3;
      ng_q[4]  <= ng3;
      car_q[4] <= car3;
      for (int s = 5; s <= 12; s++) begin
        car_q[s] <= car_q[s-1];
      end
      for (int s = 5; s <= 10; s++) begin
        ng_q[s] <= ng_q[s-1];
      end
      for (int s = 5; s <= 9; s++) begin
        z_q[s] <= z_q[s-1];
      end
      for (int l = 0; l < LANES; l++) begin
        zz_q[5][l] <= q30_mul(z_q[4][l], z_q[4][l]);
        tp_q[6][l] <= coef[6] - q30_mul(zz_q[5][l], CF9);
        for (int s = 7; s <= 9; s++) begin
          tp_q[s][l] <= coef[s] - q30_mul(zz_q[s-1][l], tp_q[s-1][l]);
        end
        sn_q[l] <= sfin[l];
      end
      for (int s = 6; s <= 9; s++) begin
        zz_q[s] <= zz_q[s-1];
      end

      mag_q[0]  <= q30_mul(sn_q[1], sn_q[2]);
      mag_q[1]  <= sn_q[0];
      mag_q[2]  <= q30_mul(sn_q[1], sn_q[3]);
      mng_q[11] <= {ng_q[10][1] ^ ng_q[10][3], ng_q[10][0], ng_q[10][1] ^ ng_q[10][2]};

      mng_q[12] <= mng_q[11];
      for (int j = 0; j < 3; j++) begin
        nr_q[j] <= 15'(nrnd[j]);
        pp_q[j] <= 47'(rad_q) * 47'(mag_q[j]);
      end

      for (int j = 0; j < 3; j++) begin
        out_pos_q[j] <= !vtx12 ? 17'sd0 :
                        (mng_q[12][j] ? -$signed(pmag[j]) : $signed(pmag[j]));
        out_nrm_q[j] <= !vtx12 ? 16'sd0 :
                        (mng_q[12][j] ? -$signed({1'b0, nr_q[j]}) : $signed({1'b0, nr_q[j]}));
      end
      out_u_q     <= vtx12 ? car_q[12].u : 16'd0;
      out_v_q     <= vtx12 ? car_q[12].v : 16'd0;
      out_idx_q   <= car_q[12].idx;
      out_bad_q   <= car_q[12].bad;
      out_multi_q <= car_q[12].op == OP_QUAD && !car_q[12].bad;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pos_x_o        = out_pos_q[0];
  assign pos_y_o        = out_pos_q[1];
  assign pos_z_o        = out_pos_q[2];
  assign norm_x_o       = out_nrm_q[0];
  assign norm_y_o       = out_nrm_q[1];
  assign norm_z_o       = out_nrm_q[2];
  assign tex_u_o        = out_u_q;
  assign tex_v_o        = out_v_q;
  assign vertex_index_o = out_multi_q ? out_idx_q[out_cnt_q] : 18'd0;
  assign last_of_run_o  = out_last;
  assign bad_request_o  = out_bad_q;

  `UVSM_ASSERT_NOW(a_div_blocks_input, div_busy_q, in_stall_o, "input taken during divide")
  `UVSM_ASSERT_NOW(a_cnt_only_quad, out_vld_q && out_cnt_q != 3'd0, out_multi_q,
                   "corner count on single-result item")
  `UVSM_ASSERT_NOW(a_bad_single, out_valid_o && bad_request_o,
                   last_of_run_o && vertex_index_o == 18'd0, "bad request not single")
  `UVSM_ASSERT_NEXT(a_stall_holds_cnt, out_vld_q && out_stall_i,
                    out_vld_q && $stable(out_cnt_q), "corner count moved under stall")

endmodule
